// ===== rtl/isbf_pkg.sv =====
// isbf_pkg: shared constants and types for the imu sample to body frame block
// no dependencies; used by every module under rtl/
`default_nettype none

package isbf_pkg;

  // fixed point formats
  localparam int COEF_FRAC_BITS = 16;
  localparam int OUT_FRAC_BITS  = 16;
  localparam int VEC_FRAC       = 24;
  localparam int COEF_W         = 18;
  localparam int ROW_W          = 3 * COEF_W;

  localparam int RAW_W      = 16;
  localparam int BIAS_W     = 24;
  localparam int BIAS_FRAC  = 8;
  localparam int GDIFF_W    = RAW_W + BIAS_FRAC + 1;
  localparam int GYRO_K_W   = 22;
  localparam int ACCEL_K_W  = 23;
  localparam int GPROD_W    = GDIFF_W + GYRO_K_W;
  localparam int APROD_W    = RAW_W + ACCEL_K_W;
  localparam int GYRO_SH    = 40 - VEC_FRAC;
  localparam int ACCEL_SH   = 32 - VEC_FRAC;

  // scaled axis values fit 30 signed bits, one more leaves room for negation
  localparam int VEC_W  = 31;
  localparam int PROD_W = COEF_W + VEC_W;
  localparam int ACC_W  = PROD_W + 2;
  localparam int RND_SH = VEC_FRAC + COEF_FRAC_BITS - OUT_FRAC_BITS;

  localparam int GYRO_OUT_W  = 22;
  localparam int ACCEL_OUT_W = 24;
  localparam int TEMP_W      = 17;

  // rad/s and m/s^2 per lsb, scaled by 2^32
  localparam logic signed [GYRO_K_W-1:0]  GYRO_K  = GYRO_K_W'(1311823);
  localparam logic signed [ACCEL_K_W-1:0] ACCEL_K = ACCEL_K_W'(2569274);
  localparam logic signed [TEMP_W-1:0]    TEMP_OFS = TEMP_W'(6400);

  localparam logic signed [GPROD_W-1:0] GYRO_HALF  = GPROD_W'(1) <<< (GYRO_SH - 1);
  localparam logic signed [APROD_W-1:0] ACCEL_HALF = APROD_W'(1) <<< (ACCEL_SH - 1);
  localparam logic signed [ACC_W-1:0]   ROT_HALF   = ACC_W'(1) <<< (RND_SH - 1);

  // identity diagonal, limited to the largest positive coefficient
  localparam longint DIAG_FULL = longint'(1) << COEF_FRAC_BITS;
  localparam longint COEF_MAX  = (longint'(1) << (COEF_W - 1)) - 1;
  localparam logic [COEF_W-1:0] DIAG =
    COEF_W'((DIAG_FULL > COEF_MAX) ? COEF_MAX : DIAG_FULL);

  localparam logic [ROW_W-1:0] ROW0_RST = {{(2*COEF_W){1'b0}}, DIAG};
  localparam logic [ROW_W-1:0] ROW1_RST = {{COEF_W{1'b0}}, DIAG, {COEF_W{1'b0}}};
  localparam logic [ROW_W-1:0] ROW2_RST = {DIAG, {(2*COEF_W){1'b0}}};

  typedef enum logic [2:0] {
    CFG_BIAS_X = 3'd0,
    CFG_BIAS_Y = 3'd1,
    CFG_BIAS_Z = 3'd2,
    CFG_ROW0   = 3'd3,
    CFG_ROW1   = 3'd4,
    CFG_ROW2   = 3'd5
  } cfg_idx_t;

  typedef logic signed [VEC_W-1:0] vec_el_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  // one sensor axis after gyro bias removal and scaling, Q.24
  typedef struct packed {
    logic signed [VEC_W-1:0] gyro;
    logic signed [VEC_W-1:0] accel;
  } axis_res_t;

  // control travelling alongside the datapath
  typedef struct packed {
    logic                     valid;
    logic signed [TEMP_W-1:0] temp;
  } mctl_t;

endpackage

`default_nettype wire

// ===== rtl/isbf_axis_lane.sv =====
// isbf_axis_lane: one sensor axis, gyro bias removal and scaling of gyro and accel
// depends on isbf_pkg
`default_nettype none

module isbf_axis_lane (
  input  wire logic                                 clk,
  input  wire logic signed [isbf_pkg::RAW_W-1:0]    gyro_raw,
  input  wire logic signed [isbf_pkg::RAW_W-1:0]    accel_raw,
  input  wire logic signed [isbf_pkg::BIAS_W-1:0]   bias,
  output isbf_pkg::axis_res_t                       res
);

  logic signed [isbf_pkg::GDIFF_W-1:0] gdiff_r, gdiff_nxt;
  logic signed [isbf_pkg::RAW_W-1:0]   araw_r;
  logic signed [isbf_pkg::GPROD_W-1:0] gprod_r, gprod_nxt, gsum;
  logic signed [isbf_pkg::APROD_W-1:0] aprod_r, aprod_nxt, asum;
  isbf_pkg::axis_res_t                 res_r, res_nxt;

  // raw in Q.8 minus bias
  assign gdiff_nxt = isbf_pkg::GDIFF_W'($signed({gyro_raw, {isbf_pkg::BIAS_FRAC{1'b0}}}))
                   - isbf_pkg::GDIFF_W'(bias);
  assign gprod_nxt = gdiff_r * isbf_pkg::GYRO_K;
  assign aprod_nxt = araw_r * isbf_pkg::ACCEL_K;

  // round half up, then drop to Q.24
  assign gsum = gprod_r + isbf_pkg::GYRO_HALF;
  assign asum = aprod_r + isbf_pkg::ACCEL_HALF;
  assign res_nxt.gyro  = gsum[isbf_pkg::GYRO_SH +: isbf_pkg::VEC_W];
  assign res_nxt.accel = asum[isbf_pkg::ACCEL_SH +: isbf_pkg::VEC_W];

  always_ff @(posedge clk) begin
    gdiff_r <= gdiff_nxt;
    araw_r  <= accel_raw;
    gprod_r <= gprod_nxt;
    aprod_r <= aprod_nxt;
    res_r   <= res_nxt;
  end

  assign res = res_r;

endmodule

`default_nettype wire

// ===== rtl/isbf_row_lane.sv =====
// isbf_row_lane: one row of the level matrix applied to the gyro and accel vectors
// depends on isbf_pkg
`default_nettype none

module isbf_row_lane (
  input  wire logic                              clk,
  input  wire logic [isbf_pkg::ROW_W-1:0]        row,
  input  wire isbf_pkg::vec_el_t                 gyro_vec [3],
  input  wire isbf_pkg::vec_el_t                 accel_vec [3],
  output isbf_pkg::acc_t                         gyro_acc,
  output isbf_pkg::acc_t                         accel_acc
);

  logic signed [isbf_pkg::COEF_W-1:0] coef [3];
  logic signed [isbf_pkg::PROD_W-1:0] gprod_r [3];
  logic signed [isbf_pkg::PROD_W-1:0] aprod_r [3];
  isbf_pkg::acc_t                     gsum, asum;
  isbf_pkg::acc_t                     gacc_r, aacc_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      coef[c] = row[c*isbf_pkg::COEF_W +: isbf_pkg::COEF_W];
    end
  end

  always_ff @(posedge clk) begin
    for (int c = 0; c < 3; c++) begin
      gprod_r[c] <= coef[c] * gyro_vec[c];
      aprod_r[c] <= coef[c] * accel_vec[c];
    end
  end

  assign gsum = isbf_pkg::ACC_W'(gprod_r[0]) + isbf_pkg::ACC_W'(gprod_r[1])
              + isbf_pkg::ACC_W'(gprod_r[2]) + isbf_pkg::ROT_HALF;
  assign asum = isbf_pkg::ACC_W'(aprod_r[0]) + isbf_pkg::ACC_W'(aprod_r[1])
              + isbf_pkg::ACC_W'(aprod_r[2]) + isbf_pkg::ROT_HALF;

  always_ff @(posedge clk) begin
    gacc_r <= gsum >>> isbf_pkg::RND_SH;
    aacc_r <= asum >>> isbf_pkg::RND_SH;
  end

  assign gyro_acc  = gacc_r;
  assign accel_acc = aacc_r;

endmodule

`default_nettype wire

// ===== rtl/isbf_out_merge.sv =====
// isbf_out_merge: gathers the row lane sums, saturates them and registers the result
// depends on isbf_pkg
`default_nettype none

module isbf_out_merge (
  input  wire logic                                      clk,
  input  wire logic                                      rst_n,
  input  wire isbf_pkg::mctl_t                           ctl,
  input  wire isbf_pkg::acc_t                            gyro_acc [3],
  input  wire isbf_pkg::acc_t                            accel_acc [3],
  output logic                                           strobe,
  output logic signed [isbf_pkg::GYRO_OUT_W-1:0]         gyro_out [3],
  output logic signed [isbf_pkg::ACCEL_OUT_W-1:0]        accel_out [3],
  output logic signed [isbf_pkg::TEMP_W-1:0]             temp_out
);

  localparam isbf_pkg::acc_t G_MAX =
    isbf_pkg::ACC_W'((longint'(1) << (isbf_pkg::GYRO_OUT_W - 1)) - 1);
  localparam isbf_pkg::acc_t G_MIN = -G_MAX - isbf_pkg::ACC_W'(1);
  localparam isbf_pkg::acc_t A_MAX =
    isbf_pkg::ACC_W'((longint'(1) << (isbf_pkg::ACCEL_OUT_W - 1)) - 1);
  localparam isbf_pkg::acc_t A_MIN = -A_MAX - isbf_pkg::ACC_W'(1);

  logic                                    strobe_r;
  logic signed [isbf_pkg::GYRO_OUT_W-1:0]  gyro_r [3];
  logic signed [isbf_pkg::ACCEL_OUT_W-1:0] accel_r [3];
  logic signed [isbf_pkg::TEMP_W-1:0]      temp_r;
  isbf_pkg::acc_t                          gclip [3];
  isbf_pkg::acc_t                          aclip [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (gyro_acc[i] > G_MAX) begin
        gclip[i] = G_MAX;
      end else if (gyro_acc[i] < G_MIN) begin
        gclip[i] = G_MIN;
      end else begin
        gclip[i] = gyro_acc[i];
      end
      if (accel_acc[i] > A_MAX) begin
        aclip[i] = A_MAX;
      end else if (accel_acc[i] < A_MIN) begin
        aclip[i] = A_MIN;
      end else begin
        aclip[i] = accel_acc[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      gyro_r[i]  <= gclip[i][isbf_pkg::GYRO_OUT_W-1:0];
      accel_r[i] <= aclip[i][isbf_pkg::ACCEL_OUT_W-1:0];
    end
    temp_r <= ctl.temp;
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= ctl.valid;
    end
  end

  assign strobe    = strobe_r;
  assign gyro_out  = gyro_r;
  assign accel_out = accel_r;
  assign temp_out  = temp_r;

endmodule

`default_nettype wire

// ===== rtl/imu_sample_to_body_frame.sv =====
// imu_sample_to_body_frame: raw imu sample to bias-corrected, scaled, levelled body frame
// every taken start produces one result strobe; one item per clock sustained
// the three axis lanes and three row lanes run in parallel
// busy is high only while rst_n is low; the receiver cannot stall
// synchronous reset clears the pipeline valids and loads zero bias and an identity matrix
// depends on isbf_pkg, isbf_axis_lane, isbf_row_lane, isbf_out_merge
`default_nettype none

module imu_sample_to_body_frame (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic signed [15:0]                     in_gyro_raw_x,
  input  wire logic signed [15:0]                     in_gyro_raw_y,
  input  wire logic signed [15:0]                     in_gyro_raw_z,
  input  wire logic signed [15:0]                     in_accel_raw_x,
  input  wire logic signed [15:0]                     in_accel_raw_y,
  input  wire logic signed [15:0]                     in_accel_raw_z,
  input  wire logic signed [15:0]                     in_temp_raw,
  input  wire logic                                   in_temp_valid,
  output logic                                        out_strobe,
  output logic signed [21:0]                          out_gyro_body_x,
  output logic signed [21:0]                          out_gyro_body_y,
  output logic signed [21:0]                          out_gyro_body_z,
  output logic signed [23:0]                          out_accel_body_x,
  output logic signed [23:0]                          out_accel_body_y,
  output logic signed [23:0]                          out_accel_body_z,
  output logic signed [16:0]                          out_temperature_q8,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic [2:0]                             cfg_index,
  input  wire logic [isbf_pkg::ROW_W-1:0]             cfg_data
);

  localparam int CTL_STAGES = 6;

  logic signed [isbf_pkg::BIAS_W-1:0] bias_r [3];
  logic [isbf_pkg::ROW_W-1:0]         row_r [3];
  isbf_pkg::mctl_t                    ctl_r [CTL_STAGES];
  isbf_pkg::axis_res_t                axis_res [3];
  isbf_pkg::vec_el_t                  gvec_r [3];
  isbf_pkg::vec_el_t                  avec_r [3];
  isbf_pkg::acc_t                     gacc [3];
  isbf_pkg::acc_t                     aacc [3];
  logic signed [isbf_pkg::RAW_W-1:0]  graw [3];
  logic signed [isbf_pkg::RAW_W-1:0]  araw [3];
  logic signed [isbf_pkg::GYRO_OUT_W-1:0]  gout [3];
  logic signed [isbf_pkg::ACCEL_OUT_W-1:0] aout [3];
  logic signed [isbf_pkg::TEMP_W-1:0] temp_nxt;
  logic                               accept;

  assign busy      = ~rst_n;
  assign cfg_ready = rst_n;
  assign accept    = start & ~busy;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        bias_r[i] <= '0;
      end
      row_r[0] <= isbf_pkg::ROW0_RST;
      row_r[1] <= isbf_pkg::ROW1_RST;
      row_r[2] <= isbf_pkg::ROW2_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        isbf_pkg::CFG_BIAS_X: bias_r[0] <= cfg_data[isbf_pkg::BIAS_W-1:0];
        isbf_pkg::CFG_BIAS_Y: bias_r[1] <= cfg_data[isbf_pkg::BIAS_W-1:0];
        isbf_pkg::CFG_BIAS_Z: bias_r[2] <= cfg_data[isbf_pkg::BIAS_W-1:0];
        isbf_pkg::CFG_ROW0:   row_r[0]  <= cfg_data;
        isbf_pkg::CFG_ROW1:   row_r[1]  <= cfg_data;
        isbf_pkg::CFG_ROW2:   row_r[2]  <= cfg_data;
        default: ;
      endcase
    end
  end

  // temperature never leaves 17 bits, so no clamp is needed
  assign temp_nxt = in_temp_valid
                  ? isbf_pkg::TEMP_W'(in_temp_raw) + isbf_pkg::TEMP_OFS
                  : '0;

  always_ff @(posedge clk) begin
    ctl_r[0].temp <= temp_nxt;
    for (int s = 1; s < CTL_STAGES; s++) begin
      ctl_r[s].temp <= ctl_r[s-1].temp;
    end
    if (!rst_n) begin
      for (int s = 0; s < CTL_STAGES; s++) begin
        ctl_r[s].valid <= 1'b0;
      end
    end else begin
      ctl_r[0].valid <= accept;
      for (int s = 1; s < CTL_STAGES; s++) begin
        ctl_r[s].valid <= ctl_r[s-1].valid;
      end
    end
  end

  assign graw[0] = in_gyro_raw_x;
  assign graw[1] = in_gyro_raw_y;
  assign graw[2] = in_gyro_raw_z;
  assign araw[0] = in_accel_raw_x;
  assign araw[1] = in_accel_raw_y;
  assign araw[2] = in_accel_raw_z;

  for (genvar a = 0; a < 3; a++) begin : g_axis
    isbf_axis_lane u_axis (
      .clk       (clk),
      .gyro_raw  (graw[a]),
      .accel_raw (araw[a]),
      .bias      (bias_r[a]),
      .res       (axis_res[a])
    );
  end

  // sensor to body axes: (-z, x, -y)
  always_ff @(posedge clk) begin
    gvec_r[0] <= -axis_res[2].gyro;
    gvec_r[1] <=  axis_res[0].gyro;
    gvec_r[2] <= -axis_res[1].gyro;
    avec_r[0] <= -axis_res[2].accel;
    avec_r[1] <=  axis_res[0].accel;
    avec_r[2] <= -axis_res[1].accel;
  end

  for (genvar r = 0; r < 3; r++) begin : g_row
    isbf_row_lane u_row (
      .clk       (clk),
      .row       (row_r[r]),
      .gyro_vec  (gvec_r),
      .accel_vec (avec_r),
      .gyro_acc  (gacc[r]),
      .accel_acc (aacc[r])
    );
  end

  isbf_out_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl_r[CTL_STAGES-1]),
    .gyro_acc  (gacc),
    .accel_acc (aacc),
    .strobe    (out_strobe),
    .gyro_out  (gout),
    .accel_out (aout),
    .temp_out  (out_temperature_q8)
  );

  assign out_gyro_body_x  = gout[0];
  assign out_gyro_body_y  = gout[1];
  assign out_gyro_body_z  = gout[2];
  assign out_accel_body_x = aout[0];
  assign out_accel_body_y = aout[1];
  assign out_accel_body_z = aout[2];

  // every taken item produces a result strobe
  a_item_out: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##7 out_strobe)
    else $error("taken item did not produce a result");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, 7))
    else $error("result strobe without a taken item");

  a_temp_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !$past(in_temp_valid, 7)) |-> (out_temperature_q8 == '0))
    else $error("invalid temperature not zeroed");

  a_bias_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && (cfg_index == isbf_pkg::CFG_BIAS_Z))
      |=> (bias_r[2] == $past(cfg_data[isbf_pkg::BIAS_W-1:0])))
    else $error("bias write lost");

  a_row_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready && (cfg_index == isbf_pkg::CFG_ROW1))
      |=> (row_r[1] == $past(cfg_data)))
    else $error("matrix row write lost");

endmodule

`default_nettype wire

// ===== verif/imu_sample_to_body_frame_tb.sv =====
// imu_sample_to_body_frame_tb: self-checking bench for the imu sample to body frame block
// queue-fed driver, strobe monitor and an in-bench predictor of bias, scale, remap and levelling
// depends on isbf_pkg and imu_sample_to_body_frame
`default_nettype none

module imu_sample_to_body_frame_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int  GYRO_MULT   = 1311823;
  localparam int  ACCEL_MULT  = 2569274;
  localparam int  TEMP_ADD    = 6400;
  localparam int  BIAS_ONE    = 256;
  localparam int  GYRO_SHIFT  = 16;
  localparam int  ACCEL_SHIFT = 8;
  localparam int  ROT_SHIFT   = 24 + isbf_pkg::COEF_FRAC_BITS - isbf_pkg::OUT_FRAC_BITS;
  localparam int  PIPE_PAD    = 12;
  localparam int  STALL_LIMIT = 2000;
  localparam int  RAND_PER_PHASE = 140;
  localparam logic [2:0] CFG_UNUSED_6 = 3'd6;
  localparam logic [2:0] CFG_UNUSED_7 = 3'd7;

  typedef struct packed {
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic signed [15:0] gz;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic signed [15:0] temp;
    logic               tvalid;
  } imu_item_t;

  typedef struct packed {
    logic signed [21:0] gbx;
    logic signed [21:0] gby;
    logic signed [21:0] gbz;
    logic signed [23:0] abx;
    logic signed [23:0] aby;
    logic signed [23:0] abz;
    logic signed [16:0] temp;
  } body_sample_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] in_gyro_raw_x = '0;
  logic signed [15:0] in_gyro_raw_y = '0;
  logic signed [15:0] in_gyro_raw_z = '0;
  logic signed [15:0] in_accel_raw_x = '0;
  logic signed [15:0] in_accel_raw_y = '0;
  logic signed [15:0] in_accel_raw_z = '0;
  logic signed [15:0] in_temp_raw = '0;
  logic               in_temp_valid = 1'b0;
  logic               out_strobe;
  logic signed [21:0] out_gyro_body_x;
  logic signed [21:0] out_gyro_body_y;
  logic signed [21:0] out_gyro_body_z;
  logic signed [23:0] out_accel_body_x;
  logic signed [23:0] out_accel_body_y;
  logic signed [23:0] out_accel_body_z;
  logic signed [16:0] out_temperature_q8;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [isbf_pkg::ROW_W-1:0] cfg_data = '0;

  // predictor copy of the register file
  logic signed [23:0]         gyro_bias [3];
  logic [isbf_pkg::ROW_W-1:0] level_rows [3];

  imu_item_t    sample_q [$];
  body_sample_t body_q [$];
  imu_item_t    held_item;
  body_sample_t want;
  int           send_idle_pct = 0;
  int           mismatch_count = 0;
  int           stall_cycles = 0;
  int           phase_idle [6] = '{0, 75, 0, 26, 75, 26};

  always #4 clk = ~clk;

  imu_sample_to_body_frame i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_gyro_raw_x      (in_gyro_raw_x),
    .in_gyro_raw_y      (in_gyro_raw_y),
    .in_gyro_raw_z      (in_gyro_raw_z),
    .in_accel_raw_x     (in_accel_raw_x),
    .in_accel_raw_y     (in_accel_raw_y),
    .in_accel_raw_z     (in_accel_raw_z),
    .in_temp_raw        (in_temp_raw),
    .in_temp_valid      (in_temp_valid),
    .out_strobe         (out_strobe),
    .out_gyro_body_x    (out_gyro_body_x),
    .out_gyro_body_y    (out_gyro_body_y),
    .out_gyro_body_z    (out_gyro_body_z),
    .out_accel_body_x   (out_accel_body_x),
    .out_accel_body_y   (out_accel_body_y),
    .out_accel_body_z   (out_accel_body_z),
    .out_temperature_q8 (out_temperature_q8),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  // round to nearest, halves up, then drop s fraction bits
  function automatic longint round_shift(input longint x, input int s);
    return (x + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clamp(input longint v, input int w);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  function automatic longint level_dot(input int r, input longint v0, input longint v1,
                                       input longint v2);
    logic signed [17:0] c0;
    logic signed [17:0] c1;
    logic signed [17:0] c2;
    c0 = level_rows[r][17:0];
    c1 = level_rows[r][35:18];
    c2 = level_rows[r][53:36];
    return round_shift(longint'(c0) * v0 + longint'(c1) * v1 + longint'(c2) * v2, ROT_SHIFT);
  endfunction

  function automatic body_sample_t transform_sample(input imu_item_t s);
    longint       g [3];
    longint       a [3];
    longint       graw [3];
    longint       araw [3];
    body_sample_t r;
    graw[0] = longint'($signed(s.gx));
    graw[1] = longint'($signed(s.gy));
    graw[2] = longint'($signed(s.gz));
    araw[0] = longint'($signed(s.ax));
    araw[1] = longint'($signed(s.ay));
    araw[2] = longint'($signed(s.az));
    for (int i = 0; i < 3; i++) begin
      g[i] = round_shift((graw[i] * BIAS_ONE - longint'(gyro_bias[i])) * GYRO_MULT,
                         GYRO_SHIFT);
      a[i] = round_shift(araw[i] * ACCEL_MULT, ACCEL_SHIFT);
    end
    // body axes are (-z, x, -y)
    r.gbx = 22'(clamp(level_dot(0, -g[2], g[0], -g[1]), 22));
    r.gby = 22'(clamp(level_dot(1, -g[2], g[0], -g[1]), 22));
    r.gbz = 22'(clamp(level_dot(2, -g[2], g[0], -g[1]), 22));
    r.abx = 24'(clamp(level_dot(0, -a[2], a[0], -a[1]), 24));
    r.aby = 24'(clamp(level_dot(1, -a[2], a[0], -a[1]), 24));
    r.abz = 24'(clamp(level_dot(2, -a[2], a[0], -a[1]), 24));
    if (s.tvalid) r.temp = 17'(clamp(longint'($signed(s.temp)) + TEMP_ADD, 17));
    else r.temp = '0;
    return r;
  endfunction

  function automatic void store_reg(input logic [2:0] idx,
                                    input logic [isbf_pkg::ROW_W-1:0] data);
    case (idx)
      isbf_pkg::CFG_BIAS_X: gyro_bias[0] = data[23:0];
      isbf_pkg::CFG_BIAS_Y: gyro_bias[1] = data[23:0];
      isbf_pkg::CFG_BIAS_Z: gyro_bias[2] = data[23:0];
      isbf_pkg::CFG_ROW0:   level_rows[0] = data;
      isbf_pkg::CFG_ROW1:   level_rows[1] = data;
      isbf_pkg::CFG_ROW2:   level_rows[2] = data;
      default: ;
    endcase
  endfunction

  function automatic imu_item_t make_item(input logic [15:0] gx, gy, gz, ax, ay, az, t,
                                          input logic tv);
    imu_item_t s;
    s = '{gx, gy, gz, ax, ay, az, t, tv};
    return s;
  endfunction

  function automatic logic [15:0] rand_raw();
    case ($urandom_range(0, 9))
      0: return 16'h7fff;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 15)) - 16'd8;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [17:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return 18'h1ffff;
      1: return 18'h20000;
      2: return 18'h0;
      3: return 18'h10000 + 18'($urandom_range(0, 2047)) - 18'd1024;
      default: return 18'($urandom());
    endcase
  endfunction

  // upper bits are noise, the block keeps only the low 24
  function automatic logic [isbf_pkg::ROW_W-1:0] rand_bias_word();
    logic [isbf_pkg::ROW_W-1:0] w;
    w = isbf_pkg::ROW_W'({$urandom(), $urandom()});
    case ($urandom_range(0, 5))
      0: w[23:0] = 24'h7fffff;
      1: w[23:0] = 24'h800000;
      2: w[23:0] = 24'($urandom_range(0, 8191)) - 24'd4096;
      default: ;
    endcase
    return w;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [isbf_pkg::ROW_W-1:0] data);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    store_reg(idx, data);
  endtask

  task automatic set_config(input logic [isbf_pkg::ROW_W-1:0] bias_w,
                            input logic [isbf_pkg::ROW_W-1:0] row_w);
    write_reg(isbf_pkg::CFG_BIAS_X, bias_w);
    write_reg(isbf_pkg::CFG_BIAS_Y, bias_w);
    write_reg(isbf_pkg::CFG_BIAS_Z, bias_w);
    write_reg(isbf_pkg::CFG_ROW0, row_w);
    write_reg(isbf_pkg::CFG_ROW1, row_w);
    write_reg(isbf_pkg::CFG_ROW2, row_w);
  endtask

  task automatic randomise_config();
    write_reg(isbf_pkg::CFG_BIAS_X, rand_bias_word());
    write_reg(isbf_pkg::CFG_BIAS_Y, rand_bias_word());
    write_reg(isbf_pkg::CFG_BIAS_Z, rand_bias_word());
    write_reg(isbf_pkg::CFG_ROW0, {rand_coef(), rand_coef(), rand_coef()});
    write_reg(isbf_pkg::CFG_ROW1, {rand_coef(), rand_coef(), rand_coef()});
    write_reg(isbf_pkg::CFG_ROW2, {rand_coef(), rand_coef(), rand_coef()});
    if ($urandom_range(0, 2) == 0)
      write_reg(CFG_UNUSED_7, isbf_pkg::ROW_W'({$urandom(), $urandom()}));
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (sample_q.size() != 0 || start || body_q.size() != 0);
    repeat (PIPE_PAD) @(negedge clk);
  endtask

  task automatic check_field(input string name, input longint want_v, input longint got_v);
    if (want_v != got_v) begin
      mismatch_count++;
      $display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
    end
  endtask

  // driver: start stays high across back-to-back items
  always @(posedge clk) begin
    if (rst_n) begin
      if (!start || !busy) begin
        if (start) body_q.push_back(transform_sample(held_item));
        if (sample_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          held_item = sample_q.pop_front();
          in_gyro_raw_x  <= held_item.gx;
          in_gyro_raw_y  <= held_item.gy;
          in_gyro_raw_z  <= held_item.gz;
          in_accel_raw_x <= held_item.ax;
          in_accel_raw_y <= held_item.ay;
          in_accel_raw_z <= held_item.az;
          in_temp_raw    <= held_item.temp;
          in_temp_valid  <= held_item.tvalid;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (body_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: result expected none actual gyro_body_x %0d", $time, out_gyro_body_x);
      end else begin
        want = body_q.pop_front();
        check_field("gyro_body_x", want.gbx, out_gyro_body_x);
        check_field("gyro_body_y", want.gby, out_gyro_body_y);
        check_field("gyro_body_z", want.gbz, out_gyro_body_z);
        check_field("accel_body_x", want.abx, out_accel_body_x);
        check_field("accel_body_y", want.aby, out_accel_body_y);
        check_field("accel_body_z", want.abz, out_accel_body_z);
        check_field("temperature_q8", want.temp, out_temperature_q8);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
        $display("%0t: timeout, no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("Mismatches found");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    logic [isbf_pkg::ROW_W-1:0] diag;
    diag = isbf_pkg::ROW_W'((isbf_pkg::COEF_FRAC_BITS >= 17) ? 18'h1ffff
                                                               : (1 << isbf_pkg::COEF_FRAC_BITS));
    for (int i = 0; i < 3; i++) gyro_bias[i] = '0;
    level_rows[0] = diag;
    level_rows[1] = diag << 18;
    level_rows[2] = diag << 36;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: field extremes, invalid temperature, single axes
    sample_q.push_back(make_item(0, 0, 0, 0, 0, 0, 0, 1'b1));
    sample_q.push_back(make_item(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                                 16'h7fff, 1'b1));
    sample_q.push_back(make_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                 16'h8000, 1'b1));
    sample_q.push_back(make_item(16'h1234, 16'h8000, 16'h7fff, 16'h0001, 16'hffff, 16'h4000,
                                 16'h7fff, 1'b0));
    sample_q.push_back(make_item(16'h7fff, 0, 0, 0, 0, 0, 16'hffff, 1'b1));
    sample_q.push_back(make_item(0, 16'h8000, 0, 0, 0, 0, 16'h0001, 1'b1));
    sample_q.push_back(make_item(0, 0, 16'h7fff, 0, 0, 0, 16'h8000, 1'b0));
    sample_q.push_back(make_item(0, 0, 0, 16'h7fff, 0, 0, 0, 1'b1));
    sample_q.push_back(make_item(0, 0, 0, 0, 16'h8000, 0, 0, 1'b1));
    sample_q.push_back(make_item(0, 0, 0, 0, 0, 16'h7fff, 0, 1'b1));
    sample_q.push_back(make_item(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                                 16'hffff, 1'b1));
    sample_q.push_back(make_item(16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa,
                                 16'h5555, 1'b1));
    wait_drained();

    // largest bias and coefficients, noise above the bias field, writes to unused indexes
    set_config({30'h2aaaaaaa, 24'h7fffff}, {3{18'h1ffff}});
    write_reg(CFG_UNUSED_6, {isbf_pkg::ROW_W{1'b1}});
    write_reg(CFG_UNUSED_7, '0);
    sample_q.push_back(make_item(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                                 16'h7fff, 1'b1));
    sample_q.push_back(make_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                 16'h8000, 1'b1));
    sample_q.push_back(make_item(16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000,
                                 0, 1'b0));
    sample_q.push_back(make_item(0, 0, 0, 0, 0, 0, 0, 1'b1));
    wait_drained();

    // most negative bias and coefficients
    set_config({30'h15555555, 24'h800000}, {3{18'h20000}});
    sample_q.push_back(make_item(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                                 16'h7fff, 1'b1));
    sample_q.push_back(make_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                 16'h8000, 1'b1));
    sample_q.push_back(make_item(0, 0, 0, 0, 0, 0, 0, 1'b0));
    sample_q.push_back(make_item(0, 0, 16'h7fff, 0, 0, 16'h8000, 16'h1000, 1'b1));
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      randomise_config();
      send_idle_pct = phase_idle[p];
      repeat (RAND_PER_PHASE)
        sample_q.push_back(make_item(rand_raw(), rand_raw(), rand_raw(), rand_raw(),
                                     rand_raw(), rand_raw(), rand_raw(),
                                     $urandom_range(0, 3) != 0));
      wait_drained();
    end

    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire
